/* rtl/uvs_pkg.sv */
// Shared constants and helpers for the UV sphere vertex generator.
// Depends on nothing; every module in rtl/ imports it.
package uvs_pkg;

   // Grid and precision settings.
   localparam int MAX_GRID       = 1024;
   localparam int TRIG_FRAC_BITS = 14;
   localparam int ANG_BITS       = 24;
   localparam int Q_BITS         = 30;

   // Phase divider: one leading quotient bit plus four per stage over six stages.
   localparam int DIV_STAGES = 6;
   localparam int DIV_STEPS  = 4;
   localparam int QUO_BITS   = 25;

   // Sine/cosine pipeline depth in registers.
   localparam int SC_LAT = 12;
   localparam int HORNER = 4;

   localparam logic [32:0] TWO_PI_Q30 = 33'd6746518852;
   localparam logic [30:0] ONE_Q30    = 31'h4000_0000;

   // Exact reciprocals for the Taylor divisors: floor(v/d) = (v*M) >> S for v < 2^30.
   // Sine divisors 72, 42, 20, 6; cosine divisors 90, 56, 30, 12.
   localparam logic [30:0] SIN_RECIP [HORNER] = '{31'd1908874354, 31'd1636178018,
                                                  31'd1717986919, 31'd1431655766};
   localparam int          SIN_SHIFT [HORNER] = '{37, 36, 35, 33};
   localparam logic [30:0] COS_RECIP [HORNER] = '{31'd1527099484, 31'd1227133514,
                                                  31'd1145324613, 31'd1431655766};
   localparam int          COS_SHIFT [HORNER] = '{37, 36, 35, 34};

   // Configuration register indexes.
   localparam logic [1:0] CSR_RADIUS = 2'd0;
   localparam logic [1:0] CSR_STACKS = 2'd1;
   localparam logic [1:0] CSR_SLICES = 2'd2;

   // Count as used by the arithmetic: zero reads as one, large values clamp.
   function automatic logic [9:0] eff_count(input logic [9:0] n);
      logic [9:0] lim;
      lim = 10'(MAX_GRID - 1);
      if (n == 10'd0) begin
         return 10'd1;
      end
      if (n > lim) begin
         return lim;
      end
      return n;
   endfunction

   // Arithmetic right shift that rounds half away from zero.
   function automatic logic signed [63:0] rnd_sym(input logic signed [63:0] v,
                                                  input int sh);
      logic [63:0] mag;
      logic [63:0] half;
      mag  = v[63] ? 64'(-v) : 64'(v);
      half = 64'd1 << (sh - 1);
      mag  = (mag + half) >> sh;
      return v[63] ? -signed'(mag) : signed'(mag);
   endfunction

endpackage

/* rtl/uvs_phase_div.sv */
// Pipelined restoring divider: quotient and remainder of dividend * 2^24 / divisor.
// Depends on uvs_pkg; the divisor must hold steady while items are in flight.
module uvs_phase_div (
   input  logic                      clock,
   input  logic [9:0]                dividend,
   input  logic [9:0]                divisor,
   output logic [uvs_pkg::QUO_BITS-1:0] quo,
   output logic [9:0]                rem
);
   import uvs_pkg::*;

   logic [9:0]          rem_ff [DIV_STAGES];
   logic [QUO_BITS-1:0] quo_ff [DIV_STAGES];
   logic                lead_ge;
   logic [9:0]          lead_rem;

   function automatic logic [QUO_BITS+9:0] div_steps(input logic [9:0] r_in,
                                                     input logic [QUO_BITS-1:0] q_in,
                                                     input logic [9:0] d);
      logic [10:0]         sh;
      logic [9:0]          r;
      logic [QUO_BITS-1:0] q;
      r = r_in;
      q = q_in;
      for (int i = 0; i < DIV_STEPS; i++) begin
         sh = {r, 1'b0};
         if (sh >= {1'b0, d}) begin
            r = 10'(sh - {1'b0, d});
            q = {q[QUO_BITS-2:0], 1'b1};
         end else begin
            r = sh[9:0];
            q = {q[QUO_BITS-2:0], 1'b0};
         end
      end
      return {r, q};
   endfunction

   // The dividend never exceeds the divisor, so the top quotient bit is one compare.
   assign lead_ge  = dividend >= divisor;
   assign lead_rem = lead_ge ? 10'(dividend - divisor) : dividend;

   always_ff @(posedge clock) begin
      {rem_ff[0], quo_ff[0]} <= div_steps(lead_rem, QUO_BITS'(lead_ge), divisor);
      for (int s = 1; s < DIV_STAGES; s++) begin
         {rem_ff[s], quo_ff[s]} <= div_steps(rem_ff[s-1], quo_ff[s-1], divisor);
      end
   end

   assign quo = quo_ff[DIV_STAGES-1];
   assign rem = rem_ff[DIV_STAGES-1];

endmodule

/* rtl/uvs_sincos.sv */
// Pipelined sine and cosine of a 24-bit phase in signed Q30 by octant folding
// and Horner-evaluated Taylor series. Depends on uvs_pkg.
module uvs_sincos (
   input  logic                       clock,
   input  logic [uvs_pkg::ANG_BITS-1:0] phase,
   output logic signed [31:0]         sin_q,
   output logic signed [31:0]         cos_q
);
   import uvs_pkg::*;

   logic [2:0]  oct_a_ff;
   logic [21:0] r_a_ff;
   logic [21:0] r_a_in;
   logic [2:0]  oct_b_ff;
   logic [29:0] x_b_ff;
   logic [2:0]  oct_c_ff;
   logic [29:0] x_c_ff;
   logic [29:0] x2_c_ff;
   logic [54:0] xprod;
   logic [59:0] x2prod;

   logic [30:0] ts_d_ff  [HORNER];
   logic [30:0] tc_d_ff  [HORNER];
   logic [29:0] x_d_ff   [HORNER];
   logic [29:0] x2_d_ff  [HORNER];
   logic [2:0]  oct_d_ff [HORNER];
   logic [29:0] ps_p_ff  [1:HORNER-1];
   logic [29:0] pc_p_ff  [1:HORNER-1];
   logic [29:0] x_p_ff   [1:HORNER-1];
   logic [29:0] x2_p_ff  [1:HORNER-1];
   logic [2:0]  oct_p_ff [1:HORNER-1];

   logic [29:0] s_f_ff;
   logic [29:0] pc_f_ff;
   logic [2:0]  oct_f_ff;
   logic signed [31:0] so;
   logic signed [31:0] co;
   logic signed [31:0] so_ff;
   logic signed [31:0] co_ff;

   function automatic logic [29:0] mulq(input logic [29:0] a, input logic [30:0] t);
      logic [60:0] p;
      p = 61'(a) * 61'(t);
      return 30'(p >> Q_BITS);
   endfunction

   function automatic logic [29:0] div_rc(input logic [29:0] v, input logic [30:0] m,
                                          input int s);
      logic [60:0] p;
      p = 61'(v) * 61'(m);
      return 30'(p >> s);
   endfunction

   // Fold into the first octant; odd octants are mirrored.
   assign r_a_in = phase[ANG_BITS-3] ?
                   22'(23'd1 << (ANG_BITS - 3)) - {1'b0, phase[ANG_BITS-4:0]} :
                   {1'b0, phase[ANG_BITS-4:0]};
   assign xprod  = 55'(r_a_ff) * 55'(TWO_PI_Q30);
   assign x2prod = 60'(x_b_ff) * 60'(x_b_ff);

   always_ff @(posedge clock) begin
      oct_a_ff <= phase[ANG_BITS-1:ANG_BITS-3];
      r_a_ff   <= r_a_in;
      oct_b_ff <= oct_a_ff;
      x_b_ff   <= 30'(xprod >> ANG_BITS);
      oct_c_ff <= oct_b_ff;
      x_c_ff   <= x_b_ff;
      x2_c_ff  <= 30'(x2prod >> Q_BITS);
   end

   // Horner chain: product stage, then reciprocal divide stage.
   always_ff @(posedge clock) begin
      ts_d_ff[0]  <= ONE_Q30 - 31'(div_rc(x2_c_ff, SIN_RECIP[0], SIN_SHIFT[0]));
      tc_d_ff[0]  <= ONE_Q30 - 31'(div_rc(x2_c_ff, COS_RECIP[0], COS_SHIFT[0]));
      x_d_ff[0]   <= x_c_ff;
      x2_d_ff[0]  <= x2_c_ff;
      oct_d_ff[0] <= oct_c_ff;
      for (int k = 1; k < HORNER; k++) begin
         ps_p_ff[k]  <= mulq(x2_d_ff[k-1], ts_d_ff[k-1]);
         pc_p_ff[k]  <= mulq(x2_d_ff[k-1], tc_d_ff[k-1]);
         x_p_ff[k]   <= x_d_ff[k-1];
         x2_p_ff[k]  <= x2_d_ff[k-1];
         oct_p_ff[k] <= oct_d_ff[k-1];
         ts_d_ff[k]  <= ONE_Q30 - 31'(div_rc(ps_p_ff[k], SIN_RECIP[k], SIN_SHIFT[k]));
         tc_d_ff[k]  <= ONE_Q30 - 31'(div_rc(pc_p_ff[k], COS_RECIP[k], COS_SHIFT[k]));
         x_d_ff[k]   <= x_p_ff[k];
         x2_d_ff[k]  <= x2_p_ff[k];
         oct_d_ff[k] <= oct_p_ff[k];
      end
      s_f_ff   <= mulq(x_d_ff[HORNER-1], ts_d_ff[HORNER-1]);
      pc_f_ff  <= mulq(x2_d_ff[HORNER-1], tc_d_ff[HORNER-1]);
      oct_f_ff <= oct_d_ff[HORNER-1];
   end

   // Last cosine term divides by two, then octant symmetry sets signs and swaps.
   always_comb begin
      logic signed [31:0] s;
      logic signed [31:0] c;
      s = signed'({2'b00, s_f_ff});
      c = signed'({1'b0, ONE_Q30 - {2'b00, pc_f_ff[29:1]}});
      case (oct_f_ff)
         3'd0:    begin so = s;  co = c;  end
         3'd1:    begin so = c;  co = s;  end
         3'd2:    begin so = c;  co = -s; end
         3'd3:    begin so = s;  co = -c; end
         3'd4:    begin so = -s; co = -c; end
         3'd5:    begin so = -c; co = -s; end
         3'd6:    begin so = -c; co = s;  end
         default: begin so = -s; co = c;  end
      endcase
   end

   always_ff @(posedge clock) begin
      so_ff <= so;
      co_ff <= co;
   end

   assign sin_q = so_ff;
   assign cos_q = co_ff;

endmodule

/* rtl/uv_sphere_vertex_generator.sv */
// Top level of the UV sphere vertex generator: config registers, index checks,
// phase dividers, two sine/cosine pipelines and output scaling. Depends on uvs_pkg.
//
//   channel  ports                          transfer when
//   -------  -----------------------------  -------------------------------
//   request  start, busy, req_*             start high and busy low
//   result   rsp_valid, rsp_*               rsp_valid high (one cycle each)
//   config   csr_valid, csr_ready, csr_*    csr_valid and csr_ready high
//
// One grid point can enter every clock cycle while busy is low. The pipeline depth
// is set by the 25-bit phase divider (six stages) and the sine/cosine pipeline
// (twelve stages), plus input, phase, normal and output registers.
// Reset is synchronous; it clears the valid bits and loads the register defaults,
// and busy stays high while reset is asserted. The result side cannot stall,
// so the pipeline only ever advances; configuration writes are accepted at once.
module uv_sphere_vertex_generator (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [9:0]         req_stack_index,
   input  logic [9:0]         req_slice_index,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata,
   output logic               rsp_valid,
   output logic signed [16:0] rsp_pos_x,
   output logic signed [16:0] rsp_pos_y,
   output logic signed [16:0] rsp_pos_z,
   output logic signed [15:0] rsp_norm_x,
   output logic signed [15:0] rsp_norm_y,
   output logic signed [15:0] rsp_norm_z,
   output logic [16:0]        rsp_tex_u,
   output logic [16:0]        rsp_tex_v,
   output logic [19:0]        rsp_vertex_index,
   output logic               rsp_quad_valid,
   output logic               rsp_index_error
);
   import uvs_pkg::*;

   typedef struct packed {
      logic        err;
      logic        quad;
      logic [19:0] vidx;
   } side_a_type;

   typedef struct packed {
      logic        err;
      logic        quad;
      logic [19:0] vidx;
      logic [16:0] tex_u;
      logic [16:0] tex_v;
   } side_b_type;

   // Configuration registers.
   logic [15:0] radius_ff, radius_in;
   logic [9:0]  stack_count_ff, stack_count_in;
   logic [9:0]  slice_count_ff, slice_count_in;
   logic [9:0]  stacks;
   logic [9:0]  slices;

   // Input stage.
   logic        accept;
   logic        in_vld_ff, in_vld_in;
   logic [9:0]  a_ff, a_in;
   logic [9:0]  b_ff, b_in;
   logic        err_ff, err_in;
   logic        quad_ff, quad_in;
   logic [20:0] vidx_full;

   // Divider outputs and side line alongside the dividers.
   logic [QUO_BITS-1:0] quo_a;
   logic [QUO_BITS-1:0] quo_b;
   logic [9:0]          rem_a;
   logic [9:0]          rem_b;
   logic                sa_vld_ff [DIV_STAGES];
   side_a_type          sa_ff     [DIV_STAGES];

   // Phase stage.
   logic                e_vld_ff, e_vld_in;
   logic [ANG_BITS-1:0] phi_ff, phi_in;
   logic [ANG_BITS-1:0] theta_ff, theta_in;
   side_b_type          e_side_ff, e_side_in;
   logic                theta_up;
   logic [25:0]         u_sum;
   logic [25:0]         v_sum;
   logic [16:0]         vq;

   // Sine/cosine outputs and side line alongside them.
   logic signed [31:0] sin_phi;
   logic signed [31:0] cos_phi;
   logic signed [31:0] sin_theta;
   logic signed [31:0] cos_theta;
   logic               sb_vld_ff [SC_LAT+1];
   side_b_type         sb_ff     [SC_LAT+1];

   // Normal stage (Q30).
   logic signed [31:0] nx_ff, nx_in;
   logic signed [31:0] ny_ff, ny_in;
   logic signed [31:0] nz_ff, nz_in;
   logic signed [63:0] rad_s;

   // Output stage.
   logic               out_vld_ff, out_vld_in;
   logic signed [16:0] pos_x_ff, pos_x_in;
   logic signed [16:0] pos_y_ff, pos_y_in;
   logic signed [16:0] pos_z_ff, pos_z_in;
   logic signed [15:0] norm_x_ff, norm_x_in;
   logic signed [15:0] norm_y_ff, norm_y_in;
   logic signed [15:0] norm_z_ff, norm_z_in;
   side_b_type         out_side_ff, out_side_in;

   // ------------------------------------------------------------------
   // Configuration port. Every write is taken immediately; an index past
   // the last register is dropped.
   // ------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_comb begin
      radius_in      = radius_ff;
      stack_count_in = stack_count_ff;
      slice_count_in = slice_count_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_RADIUS: radius_in      = csr_wdata;
            CSR_STACKS: stack_count_in = csr_wdata[9:0];
            CSR_SLICES: slice_count_in = csr_wdata[9:0];
            default:    ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff      <= 16'd256;
         stack_count_ff <= 10'd16;
         slice_count_ff <= 10'd32;
      end else begin
         radius_ff      <= radius_in;
         stack_count_ff <= stack_count_in;
         slice_count_ff <= slice_count_in;
      end
   end

   // The user must change the counts only while the pipeline is empty; the block
   // does not enforce this, and every stage reads them directly.
   assign stacks = eff_count(stack_count_ff);
   assign slices = eff_count(slice_count_ff);

   // ------------------------------------------------------------------
   // Input stage: saturate out-of-range indices and flag them.
   // ------------------------------------------------------------------
   assign busy   = reset;
   assign accept = start && !busy;

   always_comb begin
      a_in      = (req_stack_index > stacks) ? stacks : req_stack_index;
      b_in      = (req_slice_index > slices) ? slices : req_slice_index;
      err_in    = (req_stack_index > stacks) || (req_slice_index > slices);
      quad_in   = (a_in < stacks) && (b_in < slices);
      in_vld_in = accept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
      a_ff    <= a_in;
      b_ff    <= b_in;
      err_ff  <= err_in;
      quad_ff <= quad_in;
   end

   // ------------------------------------------------------------------
   // Exact quotients index * 2^24 / count. Every rounded phase and
   // texture coordinate is taken from these by adding and shifting.
   // ------------------------------------------------------------------
   uvs_phase_div u_div_stack (
      .clock    (clock),
      .dividend (a_ff),
      .divisor  (stacks),
      .quo      (quo_a),
      .rem      (rem_a)
   );

   uvs_phase_div u_div_slice (
      .clock    (clock),
      .dividend (b_ff),
      .divisor  (slices),
      .quo      (quo_b),
      .rem      (rem_b)
   );

   assign vidx_full = 21'(a_ff) * 21'({1'b0, slices} + 11'd1) + 21'(b_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < DIV_STAGES; s++) begin
            sa_vld_ff[s] <= 1'b0;
         end
      end else begin
         sa_vld_ff[0] <= in_vld_ff;
         for (int s = 1; s < DIV_STAGES; s++) begin
            sa_vld_ff[s] <= sa_vld_ff[s-1];
         end
      end
      sa_ff[0] <= '{err: err_ff, quad: quad_ff, vidx: vidx_full[19:0]};
      for (int s = 1; s < DIV_STAGES; s++) begin
         sa_ff[s] <= sa_ff[s-1];
      end
   end

   // ------------------------------------------------------------------
   // Phase stage. The stack angle spans half a turn, the slice angle a
   // full turn; the slice phase rounds up when twice the remainder
   // reaches the count. Halves round up throughout.
   // ------------------------------------------------------------------
   always_comb begin
      theta_up  = {rem_b, 1'b0} >= {1'b0, slices};
      phi_in    = ANG_BITS'((26'(quo_a) + 26'd1) >> 1);
      theta_in  = ANG_BITS'(quo_b + QUO_BITS'(theta_up));
      u_sum     = (26'(quo_b) + 26'd128) >> 8;
      v_sum     = (26'(quo_a) + 26'd128) >> 8;
      vq        = v_sum[16:0];
      e_vld_in  = sa_vld_ff[DIV_STAGES-1];
      e_side_in = '{err:   sa_ff[DIV_STAGES-1].err,
                    quad:  sa_ff[DIV_STAGES-1].quad,
                    vidx:  sa_ff[DIV_STAGES-1].vidx,
                    tex_u: u_sum[16:0],
                    tex_v: 17'(18'd65536 - 18'(vq))};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
      end else begin
         e_vld_ff <= e_vld_in;
      end
      phi_ff    <= phi_in;
      theta_ff  <= theta_in;
      e_side_ff <= e_side_in;
   end

   // ------------------------------------------------------------------
   // Sine and cosine of both angles.
   // ------------------------------------------------------------------
   uvs_sincos u_sc_phi (
      .clock (clock),
      .phase (phi_ff),
      .sin_q (sin_phi),
      .cos_q (cos_phi)
   );

   uvs_sincos u_sc_theta (
      .clock (clock),
      .phase (theta_ff),
      .sin_q (sin_theta),
      .cos_q (cos_theta)
   );

   // The side line is one stage longer so that its tail lines up with the
   // normal registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= SC_LAT; s++) begin
            sb_vld_ff[s] <= 1'b0;
         end
      end else begin
         sb_vld_ff[0] <= e_vld_ff;
         for (int s = 1; s <= SC_LAT; s++) begin
            sb_vld_ff[s] <= sb_vld_ff[s-1];
         end
      end
      sb_ff[0] <= e_side_ff;
      for (int s = 1; s <= SC_LAT; s++) begin
         sb_ff[s] <= sb_ff[s-1];
      end
   end

   // ------------------------------------------------------------------
   // Normal stage: sin phi times cos/sin theta, rounded back to Q30; y is cos phi.
   // ------------------------------------------------------------------
   always_comb begin
      nx_in = 32'(rnd_sym(64'(sin_phi) * 64'(cos_theta), Q_BITS));
      ny_in = cos_phi;
      nz_in = 32'(rnd_sym(64'(sin_phi) * 64'(sin_theta), Q_BITS));
   end

   always_ff @(posedge clock) begin
      nx_ff <= nx_in;
      ny_ff <= ny_in;
      nz_ff <= nz_in;
   end

   // ------------------------------------------------------------------
   // Output stage: scale by the radius into Q8.8 and round the normal
   // down to its output precision.
   // ------------------------------------------------------------------
   assign rad_s = signed'({48'd0, radius_ff});

   always_comb begin
      pos_x_in    = 17'(rnd_sym(rad_s * 64'(nx_ff), Q_BITS));
      pos_y_in    = 17'(rnd_sym(rad_s * 64'(ny_ff), Q_BITS));
      pos_z_in    = 17'(rnd_sym(rad_s * 64'(nz_ff), Q_BITS));
      norm_x_in   = 16'(rnd_sym(64'(nx_ff), Q_BITS - TRIG_FRAC_BITS));
      norm_y_in   = 16'(rnd_sym(64'(ny_ff), Q_BITS - TRIG_FRAC_BITS));
      norm_z_in   = 16'(rnd_sym(64'(nz_ff), Q_BITS - TRIG_FRAC_BITS));
      out_side_in = sb_ff[SC_LAT];
      out_vld_in  = sb_vld_ff[SC_LAT];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
      pos_x_ff    <= pos_x_in;
      pos_y_ff    <= pos_y_in;
      pos_z_ff    <= pos_z_in;
      norm_x_ff   <= norm_x_in;
      norm_y_ff   <= norm_y_in;
      norm_z_ff   <= norm_z_in;
      out_side_ff <= out_side_in;
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_pos_x        = pos_x_ff;
   assign rsp_pos_y        = pos_y_ff;
   assign rsp_pos_z        = pos_z_ff;
   assign rsp_norm_x       = norm_x_ff;
   assign rsp_norm_y       = norm_y_ff;
   assign rsp_norm_z       = norm_z_ff;
   assign rsp_tex_u        = out_side_ff.tex_u;
   assign rsp_tex_v        = out_side_ff.tex_v;
   assign rsp_vertex_index = out_side_ff.vidx;
   assign rsp_quad_valid   = out_side_ff.quad;
   assign rsp_index_error  = out_side_ff.err;

endmodule

/* verif/tb_uv_sphere_vertex_generator.sv */
// Self-checking testbench for the UV sphere vertex generator.
// Depends on rtl/uvs_pkg.sv and rtl/uv_sphere_vertex_generator.sv.
`timescale 1ns / 1ps

module tb_uv_sphere_vertex_generator;
   import uvs_pkg::*;

   // Index 3 decodes to no register; a write to it must leave all registers alone.
   localparam logic [1:0] CSR_UNUSED = 2'd3;
   localparam int DRAIN_CYCLES = 40;   // pipeline depth is 22
   localparam int STALL_LIMIT  = 5000;

   typedef struct {
      logic [9:0] stack;
      logic [9:0] slice;
   } grid_point_type;

   typedef struct {
      logic signed [16:0] pos_x, pos_y, pos_z;
      logic signed [15:0] norm_x, norm_y, norm_z;
      logic [16:0] tex_u, tex_v;
      logic [19:0] vertex_index;
      logic        quad_valid, index_error;
   } vertex_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [9:0] req_stack_index = '0;
   logic [9:0] req_slice_index = '0;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = CSR_RADIUS;
   logic [15:0] csr_wdata = '0;
   logic rsp_valid;
   logic signed [16:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic signed [15:0] rsp_norm_x, rsp_norm_y, rsp_norm_z;
   logic [16:0] rsp_tex_u, rsp_tex_v;
   logic [19:0] rsp_vertex_index;
   logic rsp_quad_valid, rsp_index_error;

   uv_sphere_vertex_generator dut (.*);

   always #5 clock = ~clock;

   // Shadow copies of the configuration registers, updated on each csr transfer.
   logic [15:0] radius_reg = 16'd256;
   logic [9:0]  stacks_reg = 10'd16;
   logic [9:0]  slices_reg = 10'd32;

   grid_point_type pending_points[$];
   vertex_type     expected_vertices[$];
   int          idle_pct = 0;
   int          error_count = 0;
   int          csr_transfers = 0;
   int          quiet_cycles = 0;

   // ------------------------------------------------------------------
   // Vertex arithmetic, kept at the bit widths the hardware uses.
   // ------------------------------------------------------------------

   // Right shift of a signed value, rounding half away from zero.
   function automatic longint shift_round(longint v, int sh);
      longint unsigned mag;
      mag = (v < 0) ? -v : v;
      mag = (mag + (64'd1 << (sh - 1))) >> sh;
      return (v < 0) ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic longint unsigned clamp_count(logic [9:0] n);
      if (n == 0) return 1;
      if (n > MAX_GRID - 1) return MAX_GRID - 1;
      return n;
   endfunction

   // Sine and cosine in Q30 of a phase with 2^24 steps per turn. The phase is
   // folded into one octant, mapped to radians, and fed to truncated Taylor series.
   function automatic void phase_sincos(longint unsigned phase,
                                        output longint sn, output longint cs);
      longint unsigned oct_size, p, r, x, x2, t;
      int oct;
      longint s, c;
      oct_size = 64'd1 << 21;
      p   = phase & 64'hFF_FFFF;
      oct = int'(p >> 21) & 7;
      r   = p & (oct_size - 1);
      if (oct[0]) r = oct_size - r;
      x  = (r * 64'd6746518852) >> 24;
      x2 = (x * x) >> 30;
      t = (64'd1 << 30) - x2 / 72;
      t = (64'd1 << 30) - ((x2 * t) >> 30) / 42;
      t = (64'd1 << 30) - ((x2 * t) >> 30) / 20;
      t = (64'd1 << 30) - ((x2 * t) >> 30) / 6;
      s = longint'((x * t) >> 30);
      t = (64'd1 << 30) - x2 / 90;
      t = (64'd1 << 30) - ((x2 * t) >> 30) / 56;
      t = (64'd1 << 30) - ((x2 * t) >> 30) / 30;
      t = (64'd1 << 30) - ((x2 * t) >> 30) / 12;
      t = (64'd1 << 30) - ((x2 * t) >> 30) / 2;
      c = longint'(t);
      case (oct)
         0: begin sn = s;  cs = c;  end
         1: begin sn = c;  cs = s;  end
         2: begin sn = c;  cs = -s; end
         3: begin sn = s;  cs = -c; end
         4: begin sn = -s; cs = -c; end
         5: begin sn = -c; cs = -s; end
         6: begin sn = -c; cs = s;  end
         default: begin sn = -s; cs = c; end
      endcase
   endfunction

   function automatic vertex_type sphere_vertex(grid_point_type pt);
      vertex_type v;
      longint unsigned stacks, slices, a, b, ph_phi, ph_theta, vq;
      longint sp, cp, st, ct, nx, ny, nz, rad;
      stacks = clamp_count(stacks_reg);
      slices = clamp_count(slices_reg);
      a = pt.stack;
      b = pt.slice;
      v.index_error = 1'b0;
      // Out-of-range indices are saturated and flagged.
      if (a > stacks) begin
         a = stacks;
         v.index_error = 1'b1;
      end
      if (b > slices) begin
         b = slices;
         v.index_error = 1'b1;
      end
      ph_phi   = ((a << 24) + stacks) / (2 * stacks);
      ph_theta = (((b << 25) + slices) / (2 * slices)) & 64'hFF_FFFF;
      phase_sincos(ph_phi, sp, cp);
      phase_sincos(ph_theta, st, ct);
      nx = shift_round(sp * ct, 30);
      ny = cp;
      nz = shift_round(sp * st, 30);
      rad = longint'(radius_reg);
      v.pos_x  = 17'(shift_round(rad * nx, 30));
      v.pos_y  = 17'(shift_round(rad * ny, 30));
      v.pos_z  = 17'(shift_round(rad * nz, 30));
      v.norm_x = 16'(shift_round(nx, 30 - TRIG_FRAC_BITS));
      v.norm_y = 16'(shift_round(ny, 30 - TRIG_FRAC_BITS));
      v.norm_z = 16'(shift_round(nz, 30 - TRIG_FRAC_BITS));
      v.tex_u  = 17'(((b << 17) + slices) / (2 * slices));
      vq       = ((a << 17) + stacks) / (2 * stacks);
      v.tex_v  = 17'(65536 - vq);
      v.vertex_index = 20'(a * (slices + 1) + b);
      v.quad_valid   = (a < stacks) && (b < slices);
      return v;
   endfunction

   // ------------------------------------------------------------------
   // Request driver: presents queued grid points with random gaps and
   // records the expected vertex at each accepted transfer.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      grid_point_type pt;
      logic taken;
      taken = start && !busy;
      if (taken) begin
         pt.stack = req_stack_index;
         pt.slice = req_slice_index;
         expected_vertices.push_back(sphere_vertex(pt));
      end
      if (reset) begin
         start <= 1'b0;
      end else if (!start || taken) begin
         if (pending_points.size() > 0 && $urandom_range(99) >= idle_pct) begin
            pt = pending_points.pop_front();
            start <= 1'b1;
            req_stack_index <= pt.stack;
            req_slice_index <= pt.slice;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Configuration shadow follows every csr transfer.
   always @(posedge clock) begin
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_RADIUS: radius_reg <= csr_wdata;
            CSR_STACKS: stacks_reg <= csr_wdata[9:0];
            CSR_SLICES: slices_reg <= csr_wdata[9:0];
            default: ;
         endcase
         csr_transfers <= csr_transfers + 1;
      end
   end

   // ------------------------------------------------------------------
   // Result monitor: each strobed vertex is matched to the oldest expectation.
   // ------------------------------------------------------------------
   task automatic check_field(string name, logic [19:0] exp_val, logic [19:0] act_val);
      if (exp_val !== act_val) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      vertex_type e;
      if (!reset && rsp_valid) begin
         if (expected_vertices.size() == 0) begin
            $display("%0t: vertex output with no request pending", $time);
            error_count++;
         end else begin
            e = expected_vertices.pop_front();
            check_field("pos_x", e.pos_x, rsp_pos_x);
            check_field("pos_y", e.pos_y, rsp_pos_y);
            check_field("pos_z", e.pos_z, rsp_pos_z);
            check_field("norm_x", e.norm_x, rsp_norm_x);
            check_field("norm_y", e.norm_y, rsp_norm_y);
            check_field("norm_z", e.norm_z, rsp_norm_z);
            check_field("tex_u", e.tex_u, rsp_tex_u);
            check_field("tex_v", e.tex_v, rsp_tex_v);
            check_field("vertex_index", e.vertex_index, rsp_vertex_index);
            check_field("quad_valid", e.quad_valid, rsp_quad_valid);
            check_field("index_error", e.index_error, rsp_index_error);
         end
      end
   end

   // Watchdog: any transfer on any channel counts as progress.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready) || reset) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus sequencing.
   // ------------------------------------------------------------------
   task automatic write_reg(logic [1:0] idx, logic [15:0] data);
      int seen;
      @(posedge clock);
      seen = csr_transfers;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      wait (csr_transfers != seen);
      csr_valid <= 1'b0;
   endtask

   task automatic add_point(int stack, int slice);
      grid_point_type pt;
      pt.stack = 10'(stack);
      pt.slice = 10'(slice);
      pending_points.push_back(pt);
   endtask

   // Mostly legal grid points, some beyond the count, some anywhere in 10 bits.
   function automatic int pick_index(int count);
      int sel;
      sel = $urandom_range(99);
      if (sel < 80) return $urandom_range(count, 0);
      if (sel < 90 && count < 1023) return $urandom_range(1023, count + 1);
      return $urandom_range(1023, 0);
   endfunction

   task automatic run_random(int count, int pct);
      int ns, nl;
      idle_pct = pct;
      ns = int'(clamp_count(stacks_reg));
      nl = int'(clamp_count(slices_reg));
      repeat (count) add_point(pick_index(ns), pick_index(nl));
   endtask

   // Block until every queued point is sent and every vertex is back, then let
   // the pipeline go quiet before anything touches the registers.
   task automatic drain();
      wait (pending_points.size() == 0 && !start && expected_vertices.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed points on the reset configuration (16 stacks, 32 slices):
      // poles, seams, last row and column, and indices past the counts.
      idle_pct = 0;
      add_point(0, 0);      add_point(16, 32);   add_point(16, 0);
      add_point(0, 32);     add_point(15, 31);   add_point(8, 8);
      add_point(8, 16);     add_point(4, 24);    add_point(12, 4);
      add_point(1, 1);      add_point(17, 5);    add_point(3, 33);
      add_point(1023, 1023); add_point(0, 1023); add_point(1023, 0);
      add_point(682, 341);  add_point(341, 682);
      run_random(150, 0);
      drain();

      // Largest radius on the coarsest grid.
      write_reg(CSR_RADIUS, 16'hFFFF);
      write_reg(CSR_STACKS, 16'd1);
      write_reg(CSR_SLICES, 16'd1);
      run_random(200, 74);
      drain();

      // Zero radius on the finest grid; upper data bits must be dropped.
      write_reg(CSR_RADIUS, 16'h0000);
      write_reg(CSR_STACKS, 16'hFFFF);
      write_reg(CSR_SLICES, 16'hFC00 | 16'd1023);
      add_point(1023, 1023); add_point(0, 0); add_point(1022, 1022); add_point(511, 512);
      run_random(200, 0);
      drain();

      // Zero counts act as one; a write to the unused index changes nothing.
      write_reg(CSR_RADIUS, 16'(($urandom_range(65535))));
      write_reg(CSR_STACKS, 16'd0);
      write_reg(CSR_SLICES, 16'd0);
      write_reg(CSR_UNUSED, 16'hFFFF);
      run_random(150, 12);
      drain();

      // Random configurations with every idle pattern.
      for (int ph = 0; ph < 4; ph++) begin
         write_reg(CSR_RADIUS, 16'($urandom_range(65535)));
         write_reg(CSR_STACKS, 16'($urandom_range(ph[0] ? 1023 : 40, 1)));
         write_reg(CSR_SLICES, 16'($urandom_range(ph[1] ? 1023 : 64, 1)));
         if (ph == 2) write_reg(CSR_UNUSED, 16'($urandom_range(65535)));
         run_random(210, (ph == 1) ? 74 : (ph == 3) ? 12 : 0);
         drain();
      end

      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
